// File: rtl/core/stamp_syntax_checker_unit_defines.svh
// assertion macros for the stamp syntax checker
`ifndef STAMP_SYNTAX_CHECKER_UNIT_DEFINES_SVH
`define STAMP_SYNTAX_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define SSC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssc assertion failed");

// next-cycle implication
`define SSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssc assertion failed");

`endif

// File: rtl/core/ssc_pkg.sv
// types and constants shared by the stamp syntax checker
`timescale 1ns / 1ps
package ssc_pkg;

   typedef enum logic [3:0] {
      PH_VER     = 4'd0,
      PH_VCOLON  = 4'd1,
      PH_BITS1   = 4'd2,
      PH_BITS    = 4'd3,
      PH_DATE    = 4'd4,
      PH_LOCAL   = 4'd5,
      PH_DOMAIN  = 4'd6,
      PH_EXT     = 4'd7,
      PH_RAND    = 4'd8,
      PH_COUNTER = 4'd9
   } phase_type;

   localparam logic [7:0] MaxBits       = 8'd160;
   localparam logic [7:0] BitsSat       = 8'd161;
   localparam logic [2:0] MinDateDigits = 3'd6;

   localparam logic [7:0] ChrNul   = 8'h00;
   localparam logic [7:0] ChrOne   = 8'h31;
   localparam logic [7:0] ChrColon = 8'h3A;
   localparam logic [7:0] ChrAt    = 8'h40;
   localparam logic [7:0] ChrPlus  = 8'h2B;
   localparam logic [7:0] ChrSlash = 8'h2F;
   localparam logic [7:0] ChrEq    = 8'h3D;
   localparam logic [7:0] ChrSpace = 8'h20;
   localparam logic [7:0] ChrTab   = 8'h09;
   localparam logic [7:0] ChrCr    = 8'h0D;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
   } word_type;

   typedef struct packed {
      logic [7:0] kept_byte;
      logic       kept_valid;
      logic       done_res;
      logic       verdict;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == ChrSpace) || ((c >= ChrTab) && (c <= ChrCr));
   endfunction

   function automatic logic in_alphabet(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             is_digit(c) || (c == ChrPlus) || (c == ChrSlash) || (c == ChrEq);
   endfunction

endpackage

// File: rtl/core/ssc_scan.sv
// phase machine and counters that check one byte per cycle while step is high
`timescale 1ns / 1ps
`include "stamp_syntax_checker_unit_defines.svh"
module ssc_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 strip,
   input  logic                 step,
   input  ssc_pkg::word_type    word,
   output ssc_pkg::result_type  result
);

   ssc_pkg::phase_type phase_ff, phase_in, chk_phase;
   logic [7:0] bits_ff, bits_in, chk_bits;
   logic [2:0] cnt_ff, cnt_in, chk_cnt;
   logic       mal_ff, mal_in, chk_mal;
   logic       ended_ff, ended_in;
   logic [10:0] bits_prod;
   logic [7:0]  c;
   logic        use_byte;

   assign c = word.char_byte;
   assign use_byte = !ended_ff && (c != ssc_pkg::ChrNul) && !(strip && ssc_pkg::is_ws(c));
   assign bits_prod = {3'b000, bits_ff} * 11'd10 + {7'b0000000, c[3:0]};

   // check of the byte against the current field
   always_comb begin
      chk_phase = phase_ff;
      chk_bits  = bits_ff;
      chk_cnt   = cnt_ff;
      chk_mal   = mal_ff;
      if (use_byte && !mal_ff) begin
         case (phase_ff)
            ssc_pkg::PH_VER: begin
               if (c == ssc_pkg::ChrOne) chk_phase = ssc_pkg::PH_VCOLON;
               else chk_mal = 1'b1;
            end
            ssc_pkg::PH_VCOLON: begin
               if (c == ssc_pkg::ChrColon) chk_phase = ssc_pkg::PH_BITS1;
               else chk_mal = 1'b1;
            end
            ssc_pkg::PH_BITS1, ssc_pkg::PH_BITS: begin
               if (ssc_pkg::is_digit(c)) begin
                  chk_bits  = (bits_prod > {3'b000, ssc_pkg::MaxBits}) ?
                              ssc_pkg::BitsSat : bits_prod[7:0];
                  chk_phase = ssc_pkg::PH_BITS;
               end else if (c == ssc_pkg::ChrColon && phase_ff == ssc_pkg::PH_BITS &&
                            bits_ff <= ssc_pkg::MaxBits) begin
                  chk_phase = ssc_pkg::PH_DATE;
               end else begin
                  chk_mal = 1'b1;
               end
            end
            ssc_pkg::PH_DATE: begin
               if (ssc_pkg::is_digit(c)) begin
                  if (cnt_ff < ssc_pkg::MinDateDigits) chk_cnt = cnt_ff + 3'd1;
               end else if (c == ssc_pkg::ChrColon && cnt_ff >= ssc_pkg::MinDateDigits) begin
                  chk_phase = ssc_pkg::PH_LOCAL;
               end else begin
                  chk_mal = 1'b1;
               end
            end
            ssc_pkg::PH_LOCAL: begin
               if (c == ssc_pkg::ChrAt) chk_phase = ssc_pkg::PH_DOMAIN;
               else if (c == ssc_pkg::ChrColon) chk_mal = 1'b1;
            end
            ssc_pkg::PH_DOMAIN: begin
               if (c == ssc_pkg::ChrColon) chk_phase = ssc_pkg::PH_EXT;
               else if (c == ssc_pkg::ChrAt) chk_mal = 1'b1;
            end
            ssc_pkg::PH_EXT: begin
               if (c == ssc_pkg::ChrColon) chk_phase = ssc_pkg::PH_RAND;
            end
            ssc_pkg::PH_RAND: begin
               if (c == ssc_pkg::ChrColon) chk_phase = ssc_pkg::PH_COUNTER;
               else if (!ssc_pkg::in_alphabet(c)) chk_mal = 1'b1;
            end
            ssc_pkg::PH_COUNTER: begin
               if (!ssc_pkg::in_alphabet(c)) chk_mal = 1'b1;
            end
            default: begin
               chk_mal = 1'b1;
            end
         endcase
      end
   end

   // end of value handling and result
   always_comb begin
      phase_in = phase_ff;
      bits_in  = bits_ff;
      cnt_in   = cnt_ff;
      mal_in   = mal_ff;
      ended_in = ended_ff;
      result.kept_valid = use_byte && strip;
      result.kept_byte  = (use_byte && strip) ? c : 8'h00;
      result.done_res   = word.last_byte;
      result.verdict    = word.last_byte && (chk_mal || chk_phase != ssc_pkg::PH_COUNTER);
      if (step) begin
         if (word.last_byte) begin
            phase_in = ssc_pkg::PH_VER;
            bits_in  = 8'h00;
            cnt_in   = 3'd0;
            mal_in   = 1'b0;
            ended_in = 1'b0;
         end else begin
            phase_in = chk_phase;
            bits_in  = chk_bits;
            cnt_in   = chk_cnt;
            mal_in   = chk_mal;
            ended_in = ended_ff || (c == ssc_pkg::ChrNul);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ssc_pkg::PH_VER;
         bits_ff  <= 8'h00;
         cnt_ff   <= 3'd0;
         mal_ff   <= 1'b0;
         ended_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         cnt_ff   <= cnt_in;
         mal_ff   <= mal_in;
         ended_ff <= ended_in;
      end
   end

   `SSC_ASSERT_SAME(a_verdict_on_done, clock, reset, result.verdict, result.done_res)
   `SSC_ASSERT_SAME(a_kept_needs_strip, clock, reset, result.kept_valid, strip && !ended_ff)
   `SSC_ASSERT_NEXT(a_clear_after_last, clock, reset, step && word.last_byte,
                    phase_ff == ssc_pkg::PH_VER && !mal_ff && !ended_ff && cnt_ff == 3'd0)
   `SSC_ASSERT_SAME(a_bits_bounded, clock, reset, 1'b1, bits_ff <= ssc_pkg::BitsSat)

endmodule

// File: rtl/core/ssc_out_reg.sv
// result register between the checker and the response channel
`timescale 1ns / 1ps
module ssc_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ssc_pkg::result_type  result,
   input  logic                 rsp_stall,
   output logic                 free,
   output logic                 rsp_valid,
   output ssc_pkg::result_type  rsp_word
);

   logic                valid_ff, valid_in;
   ssc_pkg::result_type word_ff;

   assign free = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// File: rtl/core/stamp_syntax_checker_unit.sv
// top level of the stamp syntax checker
// Checks a version-1 stamp one byte per word and gives one response word per
// request word: the byte echoed when kept, and on the word marked last the
// verdict (0 well-formed, 1 malformed). A new request word is taken every
// clock while the response channel is not stalled; a word passes an input
// register and then the result register, from which its response leaves.
// The phase machine and counters advance once per cycle while words step
// through them. A response that is stalled holds the input register, and
// a further request word is taken while that register is empty.
// csr_wr_en writes strip_whitespace (reset 1).
`timescale 1ns / 1ps
`include "stamp_syntax_checker_unit_defines.svh"
module stamp_syntax_checker_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_kept_byte,
   output logic       rsp_kept_valid,
   output logic       rsp_done_res,
   output logic       rsp_verdict
);

   logic                strip_ff, strip_in;
   logic                in_valid_ff, in_valid_in;
   ssc_pkg::word_type   in_word_ff;
   ssc_pkg::result_type result, rsp_word;
   logic                free, step, take;

   assign step = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;
   assign take = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !free);
   assign strip_in = csr_wr_en ? csr_wr_data : strip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff    <= 1'b1;
         in_valid_ff <= 1'b0;
      end else begin
         strip_ff    <= strip_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_word_ff.char_byte <= req_char_byte;
         in_word_ff.last_byte <= req_last_byte;
      end
   end

   ssc_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .strip  (strip_ff),
      .step   (step),
      .word   (in_word_ff),
      .result (result)
   );

   ssc_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .result    (result),
      .rsp_stall (rsp_stall),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign rsp_kept_byte  = rsp_word.kept_byte;
   assign rsp_kept_valid = rsp_word.kept_valid;
   assign rsp_done_res   = rsp_word.done_res;
   assign rsp_verdict    = rsp_word.verdict;

   `SSC_ASSERT_SAME(a_stall_needs_word, clock, reset, req_stall, in_valid_ff)
   `SSC_ASSERT_NEXT(a_take_fills_input, clock, reset, take, in_valid_ff)
   `SSC_ASSERT_NEXT(a_step_fills_output, clock, reset, step, rsp_valid)

endmodule
